// File: rtl/lpa_pkg.sv
// ---------------------------------------------------------------------------
// lpa_pkg: shared types and constants
// Entry layout, result layout, sequencer states and fixed constants of the
// linear piece adaptation block.
// ---------------------------------------------------------------------------
`default_nettype none
package lpa_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRAIN = 1'b1;

  localparam logic [1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [1:0] REG_LEARN_FACTOR = 2'd1;
  localparam logic [1:0] REG_CONSTANT     = 2'd2;
  localparam logic [1:0] REG_SPLIT_EN     = 2'd3;

  localparam logic [16:0] Q16_ONE     = 17'd65536;
  localparam logic [16:0] RATE_RESET  = 17'd6554;
  // 1.144712695 in Q16.16
  localparam logic [16:0] BEND_K      = 17'd75020;
  localparam int          DIV_STEPS   = 34;

  typedef struct packed {
    logic signed [31:0] c;
    logic        [30:0] dv;
    logic signed [31:0] w;
    logic signed [31:0] wmax;
    logic signed [31:0] wmin;
  } entry_t;

  typedef struct packed {
    logic        [3:0]  axis_out;
    logic signed [31:0] weight_out;
    logic signed [31:0] centroid_out;
    logic               is_bias;
  } res_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_R1, ST_R2, ST_R3, ST_DISP,
    ST_A_SQ, ST_A_DV, ST_A_DVN, ST_A_C, ST_A_E, ST_A_NE, ST_A_EE, ST_A_CMP,
    ST_A_BD, ST_A_BT, ST_A_DIV, ST_A_DIVW, ST_A_W, ST_A_WC, ST_A_ACC, ST_A_WB,
    ST_L_DP, ST_L_SQ, ST_L_TERM, ST_L_FIN, ST_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lpa_if.sv
// ---------------------------------------------------------------------------
// lpa_if: request and result channels
// Valid/ready channels carrying one train or write request and one result.
// ---------------------------------------------------------------------------
`default_nettype none
interface lpa_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic        [3:0]  axis;
  logic signed [31:0] value;
  logic signed [31:0] error;
  logic        [16:0] response;
  logic               useful;
  logic        [30:0] variance_in;
  logic signed [31:0] weight_in;
  logic signed [31:0] weight_max;
  logic signed [31:0] weight_min;
  logic               last;
  modport source (output valid, command, axis, value, error, response, useful,
                  variance_in, weight_in, weight_max, weight_min, last,
                  input ready);
  modport sink (input valid, command, axis, value, error, response, useful,
                variance_in, weight_in, weight_max, weight_min, last,
                output ready);
endinterface

interface lpa_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  axis_out;
  logic signed [31:0] weight_out;
  logic signed [31:0] centroid_out;
  logic signed [31:0] bend_stat;
  logic        [31:0] split_samples;
  logic               is_bias;
  modport source (output valid, axis_out, weight_out, centroid_out, bend_stat,
                  split_samples, is_bias, input ready);
  modport sink (input valid, axis_out, weight_out, centroid_out, bend_stat,
                split_samples, is_bias, output ready);
endinterface
`default_nettype wire

// File: rtl/lpa_mem.sv
// ---------------------------------------------------------------------------
// lpa_mem: axis entry memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none
module lpa_mem #(
  parameter int AXES = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(AXES)-1:0]  waddr,
  input  lpa_pkg::entry_t          wdata,
  input  wire  [$clog2(AXES)-1:0]  raddr,
  output lpa_pkg::entry_t          rdata
);
  import lpa_pkg::*;

  entry_t mem [AXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lpa_div.sv
// ---------------------------------------------------------------------------
// lpa_div: radix-2 restoring divider
// Unsigned 65-bit by 31-bit divide, one quotient bit per cycle. The caller
// guarantees the quotient fits in DIV_STEPS bits.
// ---------------------------------------------------------------------------
`default_nettype none
module lpa_div (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  [64:0]        num,
  input  wire  [30:0]        den,
  output logic               done,
  output logic [33:0]        quo
);
  import lpa_pkg::*;

  logic [30:0] rem_r;
  logic [33:0] sh_r;
  logic [30:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] t;
  logic        ge;
  logic [31:0] tsub;

  assign t    = {rem_r, sh_r[33]};
  assign ge   = t >= {1'b0, den_r};
  assign tsub = t - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[64:34];
      sh_r  <= num[33:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? tsub[30:0] : t[30:0];
      sh_r  <= {sh_r[32:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = sh_r;

endmodule
`default_nettype wire

// File: rtl/linear_piece_adapt_unit.sv
// ---------------------------------------------------------------------------
// linear_piece_adapt_unit: trains one linear piece in Q16.16
// Sequencer around the axis entry memory and a shared iterative divider.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries requests: write requests load one axis entry, train
//   requests carry one sample element, input axes first, output element
//   last with last set. out_ch returns one result per train request, none
//   per write. cfg_we/cfg_index/cfg_data write the four settings; the user
//   must write them only while idle, the block does not enforce it. A write
//   leaves the block idle. A train request reads its entry, then forms the
//   piece rate by a reciprocal multiply. An adapted input axis then walks a
//   multiply chain and the 34-step radix-2 divider, less the bend statistic
//   step when it is off and the divide when it is skipped. Skipped, frozen
//   or out-of-range axes go straight to the result, equal-bound axes skip
//   chain and divider, and a non-adapting output element skips its steps.
//   The next request can be accepted once the result is loaded.
//   One request is in flight at a time; the result sits in an output
//   register, so the next request is accepted while it waits to be taken.
//   Reset (synchronous, rst_n low) clears counters, totals, accumulator and
//   bend statistic and restores default settings; the entry memory is not
//   cleared. A stalled receiver holds the result; the block finishes the
//   next request and waits before loading it.
// ---------------------------------------------------------------------------
`default_nettype none
module linear_piece_adapt_unit #(
  parameter int AXES = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  lpa_in_if.sink       in_ch,
  lpa_out_if.source    out_ch,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [16:0]  cfg_data
);
  import lpa_pkg::*;

  localparam int AW = $clog2(AXES);
  localparam int DIVR = 2 * AXES - 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DIVR);
  localparam logic [AW-1:0] LAST_IDX = AW'(AXES - 1);
  localparam logic [6:0] LAST_AX7 = 7'(AXES - 1);
  localparam logic [6:0] AXES7 = 7'(AXES);

  state_t state_r, state_nxt;

  // settings
  logic [16:0] lr_r, lf_r;
  logic        const_r, split_en_r;

  // request
  logic signed [31:0] x_r, err_r;
  logic [16:0]        resp_r;
  logic               useful_r, last_r;
  logic [3:0]         axis_r;
  logic [AW-1:0]      idx_r;
  entry_t             ent_r;

  // datapath
  logic [33:0]        prod_r;
  logic [58:0]        nq_r;
  logic [26:0]        q0_r;
  logic [25:0]        p_r;
  logic [65:0]        sq_r;
  logic signed [50:0] dvm_r;
  logic [30:0]        dvn_r;
  logic signed [58:0] dp_r;
  logic signed [31:0] cn_r;
  logic signed [57:0] ep_r;
  logic signed [32:0] e_r;
  logic signed [33:0] num_r;
  logic signed [66:0] ne_r;
  logic [65:0]        ee_r;
  logic               flip_r, ovf_r, neg_r;
  logic [64:0]        mag_r;
  logic signed [51:0] bdm_r;
  logic signed [31:0] wn_r;
  logic signed [63:0] wc_r;
  logic [64:0]        term_r;
  res_t               res_r;

  // long-lived state
  logic signed [47:0] acc_r;
  logic signed [31:0] bend_r;
  logic [63:0]        sqerr_r;
  logic [47:0]        resp_tot_r;
  logic [31:0]        split_cnt_r;
  logic [31:0]        useful_cnt_r;

  // output register
  logic out_valid_r;
  res_t out_r;

  // memory and divider
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  logic            div_start;
  logic            div_done;
  logic [33:0]     div_quo;

  logic in_acc, adapt;
  logic [6:0] in_ax7, ax7_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign adapt  = useful_r && !const_r;
  assign in_ax7 = 7'(in_ch.axis);
  assign ax7_r  = 7'(axis_r);

  // -------------------------------------------------------------------------
  // shared combinational terms
  logic signed [32:0] d_s;
  logic [32:0]        ad;
  logic [30:0]        sqr;
  logic signed [32:0] sdiff;
  logic signed [35:0] dvs;
  logic signed [35:0] csum;
  logic [32:0]        ae_e;
  logic [31:0]        aerr;
  logic [25:0]        n_rate;
  logic [33:0]        rem_rate;
  logic signed [31:0] bsel;
  logic signed [36:0] tsum;
  logic signed [35:0] qs;
  logic signed [36:0] wsub;
  logic signed [31:0] wq, wc1;
  logic signed [48:0] accs;
  logic [65:0]        sqsum;
  logic [48:0]        rtsum;
  logic signed [31:0] bias;

  assign d_s   = 33'(x_r) - 33'(ent_r.c);
  assign ad    = d_s[32] ? 33'(-d_s) : 33'(d_s);
  assign sqr   = (|sq_r[65:47]) ? 31'h7FFFFFFF : sq_r[46:16];
  assign sdiff = $signed({2'b00, sqr}) - $signed({2'b00, ent_r.dv});
  assign dvs   = $signed({5'b0, ent_r.dv}) + 36'(dvm_r >>> 16);
  assign csum  = 36'(ent_r.c) + 36'(dp_r >>> 24);
  assign ae_e  = e_r[32] ? 33'(-e_r) : 33'(e_r);
  assign aerr  = err_r[31] ? 32'(-err_r) : 32'(err_r);
  assign n_rate   = prod_r[33:8];
  assign rem_rate = 34'(n_rate) - 34'(q0_r) * 34'(DIVR);
  assign bsel  = flip_r ? sat32(-64'(err_r)) : err_r;
  assign tsum  = 37'(bend_r) + 37'(bdm_r >>> 16);
  assign qs    = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign wsub  = 37'(ent_r.w) - 37'(qs);
  assign accs  = 49'(acc_r) + 49'(wc_r >>> 16);
  assign sqsum = {2'b00, sqerr_r} + {1'b0, term_r};
  assign rtsum = {1'b0, resp_tot_r} + 49'(resp_r);
  assign bias  = sat32(64'(cn_r) - 64'(acc_r));

  always_comb begin
    if (dvn_r == '0) wq = ent_r.w;
    else if (ovf_r) wq = neg_r ? 32'sh7FFFFFFF : 32'sh80000000;
    else wq = sat32(64'(wsub));
    wc1 = (wq > ent_r.wmax) ? ent_r.wmax : wq;
  end

  // -------------------------------------------------------------------------
  lpa_mem #(.AXES(AXES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag_r),
    .den   (dvn_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // -------------------------------------------------------------------------
  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_ch.ready   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '{c: cn_r, dv: dvn_r, w: wn_r, wmax: ent_r.wmax, wmin: ent_r.wmin};
    mem_raddr     = in_ch.last ? LAST_IDX : in_ax7[AW-1:0];
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_waddr   = in_ax7[AW-1:0];
        mem_wdata   = '{c: in_ch.value, dv: in_ch.variance_in, w: in_ch.weight_in,
                        wmax: in_ch.weight_max, wmin: in_ch.weight_min};
        if (in_acc && in_ch.command == CMD_WRITE) begin
          mem_we = in_ax7 < AXES7;
        end else if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_R1;
      ST_R1:   state_nxt = ST_R2;
      ST_R2:   state_nxt = ST_R3;
      ST_R3:   state_nxt = ST_DISP;
      ST_DISP: begin
        if (last_r) state_nxt = adapt ? ST_L_DP : ST_L_FIN;
        else if (ax7_r >= LAST_AX7 || !adapt) state_nxt = ST_EMIT;
        else if (ent_r.wmax == ent_r.wmin) state_nxt = ST_A_WC;
        else state_nxt = ST_A_SQ;
      end
      ST_A_SQ:  state_nxt = ST_A_DV;
      ST_A_DV:  state_nxt = ST_A_DVN;
      ST_A_DVN: state_nxt = ST_A_C;
      ST_A_C:   state_nxt = ST_A_E;
      ST_A_E:   state_nxt = ST_A_NE;
      ST_A_NE:  state_nxt = ST_A_EE;
      ST_A_EE:  state_nxt = ST_A_CMP;
      ST_A_CMP: state_nxt = split_en_r ? ST_A_BD : ST_A_DIV;
      ST_A_BD:  state_nxt = ST_A_BT;
      ST_A_BT:  state_nxt = ST_A_DIV;
      ST_A_DIV: begin
        if (dvn_r != '0 && !ovf_r) begin
          div_start = 1'b1;
          state_nxt = ST_A_DIVW;
        end else begin
          state_nxt = ST_A_W;
        end
      end
      ST_A_DIVW: if (div_done) state_nxt = ST_A_W;
      ST_A_W:    state_nxt = ST_A_WC;
      ST_A_WC:   state_nxt = ST_A_ACC;
      ST_A_ACC:  state_nxt = ST_A_WB;
      ST_A_WB: begin
        mem_we    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_L_DP:   state_nxt = ST_L_SQ;
      ST_L_SQ:   state_nxt = ST_L_TERM;
      ST_L_TERM: state_nxt = ST_L_FIN;
      ST_L_FIN: begin
        mem_we    = adapt;
        mem_wdata = '{c: cn_r, dv: ent_r.dv, w: ent_r.w, wmax: ent_r.wmax,
                      wmin: ent_r.wmin};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= RATE_RESET;
      lf_r       <= Q16_ONE;
      const_r    <= 1'b0;
      split_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE:   lr_r <= (cfg_data > Q16_ONE) ? Q16_ONE : cfg_data;
        REG_LEARN_FACTOR: lf_r <= (cfg_data > Q16_ONE) ? Q16_ONE : cfg_data;
        REG_CONSTANT:     const_r <= cfg_data[0];
        REG_SPLIT_EN:     split_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r      <= in_ch.value;
        err_r    <= in_ch.error;
        resp_r   <= (in_ch.response > Q16_ONE) ? Q16_ONE : in_ch.response;
        useful_r <= in_ch.useful;
        last_r   <= in_ch.last;
        axis_r   <= in_ch.last ? 4'(AXES - 1) : in_ch.axis;
        idx_r    <= mem_raddr;
      end
      ST_RD: begin
        ent_r  <= mem_rdata;
        prod_r <= 34'(lr_r) * 34'(lf_r);
      end
      ST_R1: nq_r <= 59'(n_rate) * 59'(RECIP);
      ST_R2: q0_r <= nq_r[58:32];
      // reciprocal estimate is at most one low
      ST_R3: p_r <= (rem_rate >= 34'(DIVR)) ? 26'(q0_r + 27'd1) : 26'(q0_r);
      ST_DISP: begin
        wn_r  <= ent_r.w;
        cn_r  <= ent_r.c;
        dvn_r <= ent_r.dv;
        if (ax7_r >= LAST_AX7) res_r <= '{axis_out: axis_r, weight_out: '0,
                                          centroid_out: '0, is_bias: 1'b0};
        else res_r <= '{axis_out: axis_r, weight_out: ent_r.w,
                        centroid_out: ent_r.c, is_bias: 1'b0};
      end
      ST_A_SQ:  sq_r <= 66'(ad) * 66'(ad);
      ST_A_DV:  dvm_r <= sdiff * $signed({1'b0, lr_r});
      ST_A_DVN: begin
        dvn_r <= dvs[35] ? '0 : dvs[30:0];
        dp_r  <= d_s * $signed({1'b0, p_r});
      end
      ST_A_C: begin
        cn_r <= sat32(64'(csum));
        ep_r <= err_r * $signed({1'b0, p_r});
      end
      ST_A_E: begin
        e_r   <= 33'(x_r) - 33'(cn_r);
        num_r <= 34'(ep_r >>> 24);
      end
      ST_A_NE: ne_r <= num_r * e_r;
      ST_A_EE: ee_r <= 66'(ae_e) * 66'(ae_e);
      ST_A_CMP: begin
        flip_r <= ee_r > 66'(BEND_K) * 66'(dvn_r);
        neg_r  <= ne_r[66];
        mag_r  <= ne_r[66] ? 65'(-ne_r) : 65'(ne_r);
        ovf_r  <= (ne_r[66] ? 65'(-ne_r) : 65'(ne_r)) >= {dvn_r, 34'b0};
      end
      ST_A_BD: bdm_r <= (34'(bsel) - 34'(bend_r)) * $signed({1'b0, lr_r});
      ST_A_W:  wn_r <= (wc1 < ent_r.wmin) ? ent_r.wmin : wc1;
      ST_A_WC: wc_r <= wn_r * cn_r;
      ST_A_WB: res_r <= '{axis_out: axis_r, weight_out: wn_r, centroid_out: cn_r,
                          is_bias: 1'b0};
      ST_L_DP: dp_r <= d_s * $signed({1'b0, p_r});
      ST_L_SQ: begin
        sq_r <= 66'(aerr) * 66'(aerr);
        cn_r <= sat32(64'(csum));
      end
      ST_L_TERM: term_r <= 65'(sq_r[63:16]) * 65'(resp_r);
      ST_L_FIN: begin
        if (adapt) res_r <= '{axis_out: axis_r, weight_out: bias,
                              centroid_out: cn_r, is_bias: 1'b1};
        else res_r <= '{axis_out: axis_r, weight_out: '0,
                        centroid_out: ent_r.c, is_bias: 1'b0};
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // accumulator, bend statistic, counters and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      bend_r       <= '0;
      sqerr_r      <= '0;
      resp_tot_r   <= '0;
      split_cnt_r  <= '0;
      useful_cnt_r <= '0;
    end else begin
      if (state_r == ST_A_BT) bend_r <= sat32(64'(tsum));
      if (state_r == ST_A_ACC) begin
        if (accs > 49'sh7FFFFFFFFFFF) acc_r <= 48'sh7FFFFFFFFFFF;
        else if (accs < -49'sh800000000000) acc_r <= 48'sh800000000000;
        else acc_r <= accs[47:0];
      end
      if (state_r == ST_L_FIN) begin
        acc_r <= '0;
        if (useful_r && useful_cnt_r != '1) useful_cnt_r <= useful_cnt_r + 32'd1;
        if (adapt) begin
          if (split_cnt_r != '1) split_cnt_r <= split_cnt_r + 32'd1;
          sqerr_r    <= (|sqsum[65:64]) ? '1 : sqsum[63:0];
          resp_tot_r <= rtsum[48] ? '1 : rtsum[47:0];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      out_r <= res_r;
      out_ch.bend_stat     <= bend_r;
      out_ch.split_samples <= split_cnt_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.axis_out     = out_r.axis_out;
  assign out_ch.weight_out   = out_r.weight_out;
  assign out_ch.centroid_out = out_r.centroid_out;
  assign out_ch.is_bias      = out_r.is_bias;

endmodule
`default_nettype wire

// File: rtl/lpa_checker.sv
// ---------------------------------------------------------------------------
// lpa_checker: port-level checks
// Watches the channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none
module lpa_checker #(
  parameter int AXES = 16
) (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       in_command,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] out_axis_out,
  input wire       out_is_bias
);
  import lpa_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  a_train_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_TRAIN |=> !in_ready)
    else $error("train request did not occupy the sequencer");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_WRITE |=> in_ready)
    else $error("write request stalled the input");

  a_bias_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bias |-> out_axis_out == 4'(AXES - 1))
    else $error("bias reported on an input axis");

endmodule

bind linear_piece_adapt_unit lpa_checker #(.AXES(AXES)) u_lpa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_command   (in_ch.command),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_axis_out (out_ch.axis_out),
  .out_is_bias  (out_ch.is_bias)
);
`default_nettype wire
